@@ design/pld3_pkg.sv @@
// Shared types and constants for the point-to-line distance core.
// Used by every module of the core; has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pld3_pkg;
   localparam int COORD_WIDTH = 16;
   localparam int FRAC_BITS   = 8;
   localparam int DIST_WIDTH  = 25;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int CROSS_W     = PROD_W + 1;
   localparam int MAG_W       = PROD_W;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int NUM_W       = SUM_W + 2 * FRAC_BITS;
   localparam int Q_W         = 2 * DIST_WIDTH;
   localparam int TOP_W       = NUM_W - Q_W;
   localparam int LEN_W       = PROD_W;
   localparam int ROOT_W      = DIST_WIDTH;
   localparam int REM_W       = DIST_WIDTH + 2;
   localparam int DIV_CELLS   = Q_W;
   localparam int SQRT_CELLS  = DIST_WIDTH;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] start_z;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
      logic signed [COORD_WIDTH-1:0] end_z;
   } req_type;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      logic                  degenerate;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic degenerate;
      logic saturate;
   } ctrl_type;
endpackage
`default_nettype wire

@@ design/pld3_front.sv @@
// Front pipeline: differences, cross product, squared lengths, division setup.
// Depends on pld3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pld3_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire pld3_pkg::req_type         req,
   output pld3_pkg::ctrl_type             ctrl_out,
   output logic [pld3_pkg::LEN_W-1:0]     rem_out,
   output logic [pld3_pkg::Q_W-1:0]       word_out,
   output logic [pld3_pkg::LEN_W-1:0]     len_out
);
   localparam int DW = pld3_pkg::DIFF_W;
   localparam int PW = pld3_pkg::PROD_W;
   localparam int CW = pld3_pkg::CROSS_W;
   localparam int MW = pld3_pkg::MAG_W;
   localparam int SW = pld3_pkg::SQ_W;
   localparam int LW = pld3_pkg::LEN_W;
   localparam int NW = pld3_pkg::NUM_W;
   localparam int QW = pld3_pkg::Q_W;
   localparam int TW = pld3_pkg::TOP_W;
   localparam int UW = pld3_pkg::SUM_W;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [DW-1:0] abx_ff, aby_ff, abz_ff, apx_ff, apy_ff, apz_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [PW-1:0] lx_ff, ly_ff, lz_ff;
   logic [MW-1:0]        mx_ff, my_ff, mz_ff;
   logic [LW-1:0]        len3_ff, len4_ff, len5_ff;
   logic                 deg3_ff, deg4_ff, deg5_ff, sat5_ff;
   logic [SW-1:0]        sx_ff, sy_ff, sz_ff;
   logic [LW-1:0]        rem5_ff;
   logic [QW-1:0]        word5_ff;

   logic signed [CW-1:0] cx_in, cy_in, cz_in;
   logic [LW-1:0]        len3_in;
   logic [UW-1:0]        sum_in;
   logic [NW-1:0]        num_in;
   logic [TW-1:0]        top_in;

   function automatic logic [MW-1:0] mag(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] a;
      a = v[CW-1] ? -v : v;
      return a[MW-1:0];
   endfunction

   always_comb begin
      cx_in   = CW'(p0_ff) - CW'(p1_ff);
      cy_in   = CW'(p2_ff) - CW'(p3_ff);
      cz_in   = CW'(p4_ff) - CW'(p5_ff);
      len3_in = LW'(lx_ff) + LW'(ly_ff) + LW'(lz_ff);
      sum_in  = UW'(sx_ff) + UW'(sy_ff) + UW'(sz_ff);
      num_in  = NW'(sum_in) << (2 * pld3_pkg::FRAC_BITS);
      top_in  = num_in[NW-1:QW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      abx_ff <= DW'(req.end_x) - DW'(req.start_x);
      aby_ff <= DW'(req.end_y) - DW'(req.start_y);
      abz_ff <= DW'(req.end_z) - DW'(req.start_z);
      apx_ff <= DW'(req.point_x) - DW'(req.start_x);
      apy_ff <= DW'(req.point_y) - DW'(req.start_y);
      apz_ff <= DW'(req.point_z) - DW'(req.start_z);

      p0_ff <= aby_ff * apz_ff;
      p1_ff <= abz_ff * apy_ff;
      p2_ff <= abz_ff * apx_ff;
      p3_ff <= abx_ff * apz_ff;
      p4_ff <= abx_ff * apy_ff;
      p5_ff <= aby_ff * apx_ff;
      lx_ff <= abx_ff * abx_ff;
      ly_ff <= aby_ff * aby_ff;
      lz_ff <= abz_ff * abz_ff;

      mx_ff   <= mag(cx_in);
      my_ff   <= mag(cy_in);
      mz_ff   <= mag(cz_in);
      len3_ff <= len3_in;
      deg3_ff <= (len3_in == '0);

      sx_ff   <= mx_ff * mx_ff;
      sy_ff   <= my_ff * my_ff;
      sz_ff   <= mz_ff * mz_ff;
      len4_ff <= len3_ff;
      deg4_ff <= deg3_ff;

      len5_ff  <= len4_ff;
      deg5_ff  <= deg4_ff;
      sat5_ff  <= (top_in >= TW'(len4_ff));
      rem5_ff  <= top_in[LW-1:0];
      word5_ff <= num_in[QW-1:0];
   end

   assign ctrl_out = '{valid: v5_ff, degenerate: deg5_ff, saturate: sat5_ff};
   assign rem_out  = rem5_ff;
   assign word_out = word5_ff;
   assign len_out  = len5_ff;
endmodule
`default_nettype wire

@@ design/pld3_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per request.
// Depends on pld3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pld3_div_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pld3_pkg::ctrl_type        ctrl_in,
   input  wire logic [pld3_pkg::LEN_W-1:0] rem_in,
   input  wire logic [pld3_pkg::Q_W-1:0]   word_in,
   input  wire logic [pld3_pkg::LEN_W-1:0] len_in,
   output pld3_pkg::ctrl_type             ctrl_out,
   output logic [pld3_pkg::LEN_W-1:0]     rem_out,
   output logic [pld3_pkg::Q_W-1:0]       word_out,
   output logic [pld3_pkg::LEN_W-1:0]     len_out
);
   localparam int LW = pld3_pkg::LEN_W;
   localparam int QW = pld3_pkg::Q_W;

   logic                 valid_ff;
   pld3_pkg::ctrl_type   ctrl_ff;
   logic [LW-1:0]        rem_ff, len_ff;
   logic [QW-1:0]        word_ff;
   logic [LW:0]          trial_in, diff_in;
   logic                 ge_in;

   always_comb begin
      trial_in = {rem_in, word_in[QW-1]};
      ge_in    = (trial_in >= {1'b0, len_in});
      diff_in  = ge_in ? trial_in - {1'b0, len_in} : trial_in;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= ctrl_in.valid;
   end

   always_ff @(posedge clock) begin
      ctrl_ff <= ctrl_in;
      rem_ff  <= diff_in[LW-1:0];
      word_ff <= {word_in[QW-2:0], ge_in};
      len_ff  <= len_in;
   end

   assign ctrl_out = '{valid: valid_ff, degenerate: ctrl_ff.degenerate,
                       saturate: ctrl_ff.saturate};
   assign rem_out  = rem_ff;
   assign word_out = word_ff;
   assign len_out  = len_ff;
endmodule
`default_nettype wire

@@ design/pld3_sqrt_cell.sv @@
// One integer square-root cell: produces one root bit per request.
// Depends on pld3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pld3_sqrt_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pld3_pkg::ctrl_type         ctrl_in,
   input  wire logic [pld3_pkg::REM_W-1:0]  rem_in,
   input  wire logic [pld3_pkg::ROOT_W-1:0] root_in,
   input  wire logic [pld3_pkg::Q_W-1:0]    word_in,
   output pld3_pkg::ctrl_type              ctrl_out,
   output logic [pld3_pkg::REM_W-1:0]      rem_out,
   output logic [pld3_pkg::ROOT_W-1:0]     root_out,
   output logic [pld3_pkg::Q_W-1:0]        word_out
);
   localparam int RW = pld3_pkg::REM_W;
   localparam int OW = pld3_pkg::ROOT_W;
   localparam int QW = pld3_pkg::Q_W;

   logic               valid_ff;
   pld3_pkg::ctrl_type ctrl_ff;
   logic [RW-1:0]      rem_ff;
   logic [OW-1:0]      root_ff;
   logic [QW-1:0]      word_ff;
   logic [RW+1:0]      shifted_in, trial_in, diff_in;
   logic               ge_in;

   always_comb begin
      shifted_in = {rem_in, word_in[QW-1:QW-2]};
      trial_in   = (RW + 2)'({root_in, 2'b01});
      ge_in      = (shifted_in >= trial_in);
      diff_in    = ge_in ? shifted_in - trial_in : shifted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= ctrl_in.valid;
   end

   always_ff @(posedge clock) begin
      ctrl_ff <= ctrl_in;
      rem_ff  <= diff_in[RW-1:0];
      root_ff <= {root_in[OW-2:0], ge_in};
      word_ff <= {word_in[QW-3:0], 2'b00};
   end

   assign ctrl_out = '{valid: valid_ff, degenerate: ctrl_ff.degenerate,
                       saturate: ctrl_ff.saturate};
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign word_out = word_ff;
endmodule
`default_nettype wire

@@ design/point_to_line_distance_3d_core.sv @@
// Top level of the 3-D point-to-line distance core: front pipeline,
// division cell chain, square-root cell chain. Depends on pld3_pkg, pld3_front and the cells.
//
//   channel   ports                       direction   handshake
//   request   start, busy, req_data       in          start && !busy
//   response  rsp_valid, rsp_data         out         one-cycle strobe
//
// A request is taken every cycle; busy is always low.
// Pipeline: 5 front stages, 50 division cells, 25 root cells and 1 output
// register; each cell yields one quotient bit or one root bit.
// Synchronous reset clears all valid flags; no result follows reset.
// The receiver cannot stall, so nothing in the chain ever holds.
`timescale 1ns / 1ps
`default_nettype none
module point_to_line_distance_3d_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire pld3_pkg::req_type req_data,
   output logic                   rsp_valid,
   output pld3_pkg::rsp_type      rsp_data
);
   localparam int LW = pld3_pkg::LEN_W;
   localparam int QW = pld3_pkg::Q_W;
   localparam int RW = pld3_pkg::REM_W;
   localparam int OW = pld3_pkg::ROOT_W;
   localparam int ND = pld3_pkg::DIV_CELLS;
   localparam int NS = pld3_pkg::SQRT_CELLS;

   pld3_pkg::ctrl_type dctrl [ND+1];
   logic [LW-1:0]      drem  [ND+1];
   logic [QW-1:0]      dword [ND+1];
   logic [LW-1:0]      dlen  [ND+1];

   pld3_pkg::ctrl_type sctrl [NS+1];
   logic [RW-1:0]      srem  [NS+1];
   logic [OW-1:0]      sroot [NS+1];
   logic [QW-1:0]      sword [NS+1];

   logic               rsp_valid_ff;
   pld3_pkg::rsp_type  rsp_ff;

   assign busy = 1'b0;

   pld3_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .req      (req_data),
      .ctrl_out (dctrl[0]),
      .rem_out  (drem[0]),
      .word_out (dword[0]),
      .len_out  (dlen[0])
   );

   for (genvar i = 0; i < ND; i++) begin : g_div
      pld3_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl_in  (dctrl[i]),
         .rem_in   (drem[i]),
         .word_in  (dword[i]),
         .len_in   (dlen[i]),
         .ctrl_out (dctrl[i+1]),
         .rem_out  (drem[i+1]),
         .word_out (dword[i+1]),
         .len_out  (dlen[i+1])
      );
   end

   assign sctrl[0] = dctrl[ND];
   assign srem[0]  = '0;
   assign sroot[0] = '0;
   assign sword[0] = dword[ND];

   for (genvar j = 0; j < NS; j++) begin : g_sqrt
      pld3_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl_in  (sctrl[j]),
         .rem_in   (srem[j]),
         .root_in  (sroot[j]),
         .word_in  (sword[j]),
         .ctrl_out (sctrl[j+1]),
         .rem_out  (srem[j+1]),
         .root_out (sroot[j+1]),
         .word_out (sword[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= sctrl[NS].valid;
   end

   always_ff @(posedge clock) begin
      rsp_ff.degenerate <= sctrl[NS].degenerate;
      if (sctrl[NS].degenerate) begin
         rsp_ff.distance <= '0;
      end else if (sctrl[NS].saturate) begin
         rsp_ff.distance <= '1;
      end else begin
         rsp_ff.distance <= sroot[NS];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire
